// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// PES scrambling detector assertion macros
// Assertion macros shared by the RTL files of the PES scrambling detector.
// ----------------------------------------------------------------------------
// Each macro samples on the rising edge of clk; the reset-qualified form
// is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds only outside reset.
`define PSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds on every edge, reset included.
`define PSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// PES scrambling detector package
// Shared constants, status codes and the parser-to-output result type.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Default sector length in bytes.
  localparam int SECTOR_BYTES_DEF = 2048;

  // Byte positions inside a sector and inside the first PES header.
  localparam int PACK_CODE_LEN   = 4;
  localparam int POS_STUFF       = 13;
  localparam int PES_BASE_OFFSET = 14;
  localparam int REL_PREFIX_LEN  = 3;
  localparam int REL_STREAM_ID   = 3;
  localparam int REL_FLAGS       = 6;

  // Start code bytes and header field values.
  localparam logic [7:0] CODE_ZERO      = 8'h00;
  localparam logic [7:0] CODE_ONE       = 8'h01;
  localparam logic [7:0] CODE_PACK      = 8'hBA;
  localparam logic [7:0] STUFF_MASK     = 8'h07;
  localparam logic [7:0] SID_PRIVATE_1  = 8'hBD;
  localparam logic [7:0] SID_AV_LOW     = 8'hC0;
  localparam logic [7:0] SID_AV_HIGH    = 8'hEF;
  localparam logic [7:0] MARKER_MASK    = 8'hC0;
  localparam logic [7:0] MARKER_VALUE   = 8'h80;
  localparam logic [7:0] SCRAMBLE_MASK  = 8'h30;

  // Per-sector status.
  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_NO_EXT    = 2'd1,
    ST_CLEAR     = 2'd2,
    ST_SCRAMBLED = 2'd3
  } sector_status_t;

  // Running verdict over a scan.
  typedef enum logic [1:0] {
    VD_INCONCLUSIVE = 2'd0,
    VD_PLAIN        = 2'd1,
    VD_SCRAMBLED    = 2'd2
  } verdict_t;

  // One sector result handed from the parser to the output register.
  typedef struct packed {
    sector_status_t status;
    verdict_t       verdict;
    logic           is_final;
  } psd_result_t;

  // Byte idx of the start code 00 00 01 BA; the PES prefix uses the first three.
  function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
    logic [7:0] code;
    unique case (idx)
      2'd0:    code = CODE_ZERO;
      2'd1:    code = CODE_ZERO;
      2'd2:    code = CODE_ONE;
      default: code = CODE_PACK;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/psd_in_if.sv =====
// ----------------------------------------------------------------------------
// PES scrambling detector input channel
// Valid/ready channel carrying one sector byte and its end markers.
// ----------------------------------------------------------------------------
interface psd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sector_last;
  logic       scan_last;

  modport source (output valid, output data_byte, output sector_last,
                  output scan_last, input ready);
  modport sink   (input valid, input data_byte, input sector_last,
                  input scan_last, output ready);
endinterface

// ===== rtl/core/psd_out_if.sv =====
// ----------------------------------------------------------------------------
// PES scrambling detector result channel
// Valid/ready channel carrying one sector status and the running verdict.
// ----------------------------------------------------------------------------
interface psd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] sector_status;
  logic [1:0] verdict;
  logic       verdict_final;

  modport source (output valid, output sector_status, output verdict,
                  output verdict_final, input ready);
  modport sink   (input valid, input sector_status, input verdict,
                  input verdict_final, output ready);
endinterface

// ===== rtl/core/pes_scrambling_detector.sv =====
// A result is valid in the cycle after the transfer of a sector's last byte.
// Throughput: one byte per cycle while the input is not stalled; every byte is judged in the cycle it is taken.
// Input stalls only while a finished result is held and the sink does not take it.
// Reset: synchronous, active low; clears position, header flags and scan verdict.
// ----------------------------------------------------------------------------
// PES scrambling detector
// Checks the pack and first PES header of each sector for scrambling control
// bits and reports a per-sector status and a running verdict over the scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pes_scrambling_detector #(
  parameter int SECTOR_BYTES = psd_pkg::SECTOR_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  psd_in_if.sink       in_ch,
  psd_out_if.source    out_ch
);

  logic                 take;
  logic                 in_ready;
  psd_pkg::psd_result_t result;

  logic                 out_valid_r;
  psd_pkg::psd_result_t out_r;

  // A new byte is taken unless a held result is still waiting.
  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign take        = in_ch.valid && in_ready;

  psd_parser #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_ch.data_byte),
    .sector_last (in_ch.sector_last),
    .scan_last   (in_ch.scan_last),
    .result      (result)
  );

  // Result register: loaded at a sector-end transfer, freed when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && in_ch.sector_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ch.sector_last) begin
      out_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sector_status = out_r.status;
  assign out_ch.verdict       = out_r.verdict;
  assign out_ch.verdict_final = out_r.is_final;

  // Every sector-end transfer leaves a result waiting.
  `PSD_ASSERT(a_result_loaded, (take && in_ch.sector_last) |=> out_valid_r, "sector end without result")
  // A scrambled sector always yields a scrambled verdict.
  `PSD_ASSERT(a_scr_verdict, (out_valid_r && (out_r.status == psd_pkg::ST_SCRAMBLED)) |-> (out_r.verdict == psd_pkg::VD_SCRAMBLED), "scrambled sector with non-scrambled verdict")
  // With no result held the input is always open.
  `PSD_ASSERT(a_ready_when_empty, !out_valid_r |-> in_ready, "input blocked with no result held")

endmodule

// ===== rtl/core/psd_parser.sv =====
// ----------------------------------------------------------------------------
// PES scrambling detector sector parser
// Tracks the byte position in a sector, checks the pack and PES start codes,
// judges the PES flags byte and keeps the per-scan flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psd_parser #(
  parameter int SECTOR_BYTES = psd_pkg::SECTOR_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 sector_last,
  input  logic                 scan_last,
  output psd_pkg::psd_result_t result
);

  localparam int POS_W = $clog2(SECTOR_BYTES);
  localparam logic [POS_W-1:0] POS_MAX    = POS_W'(SECTOR_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PACK   = POS_W'(psd_pkg::PACK_CODE_LEN);
  localparam logic [POS_W-1:0] POS_STUFF  = POS_W'(psd_pkg::POS_STUFF);
  localparam logic [POS_W-1:0] REL_PREFIX = POS_W'(psd_pkg::REL_PREFIX_LEN);
  localparam logic [POS_W-1:0] REL_SID    = POS_W'(psd_pkg::REL_STREAM_ID);
  localparam logic [POS_W-1:0] REL_FLAGS  = POS_W'(psd_pkg::REL_FLAGS);
  localparam logic [4:0]       OFF_BASE   = 5'(psd_pkg::PES_BASE_OFFSET);

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [4:0]              off_r, off_nxt;
  logic                    match_r, match_nxt;
  logic                    ext_r, ext_nxt;
  psd_pkg::sector_status_t status_r, status_nxt;
  logic                    valid_pes_r, valid_pes_nxt;
  logic                    scr_r, scr_nxt;

  logic [POS_W-1:0]        rel;
  logic [7:0]              stuff;

  assign rel   = pos_r - POS_W'(off_r);
  assign stuff = data_byte & psd_pkg::STUFF_MASK;

  // Header checks for the current byte, then the sector-end restart.
  always_comb begin
    pos_nxt       = pos_r;
    off_nxt       = off_r;
    match_nxt     = match_r;
    ext_nxt       = ext_r;
    status_nxt    = status_r;
    valid_pes_nxt = valid_pes_r;
    scr_nxt       = scr_r;

    priority if (pos_r < POS_PACK) begin
      if (data_byte != psd_pkg::start_code_byte(pos_r[1:0])) begin
        match_nxt = 1'b0;
      end
    end else if (pos_r == POS_STUFF) begin
      off_nxt = OFF_BASE + stuff[4:0];
    end else if (pos_r >= POS_W'(off_r)) begin
      priority if (rel < REL_PREFIX) begin
        if (data_byte != psd_pkg::start_code_byte(rel[1:0])) begin
          match_nxt = 1'b0;
        end
      end else if (rel == REL_SID) begin
        ext_nxt = (data_byte == psd_pkg::SID_PRIVATE_1) ||
                  ((data_byte >= psd_pkg::SID_AV_LOW) &&
                   (data_byte <= psd_pkg::SID_AV_HIGH));
      end else if (rel == REL_FLAGS) begin
        priority if (!match_r) begin
          status_nxt = psd_pkg::ST_NONE;
        end else if (ext_r &&
                     ((data_byte & psd_pkg::MARKER_MASK) == psd_pkg::MARKER_VALUE)) begin
          valid_pes_nxt = 1'b1;
          if ((data_byte & psd_pkg::SCRAMBLE_MASK) != 8'h00) begin
            scr_nxt    = 1'b1;
            status_nxt = psd_pkg::ST_SCRAMBLED;
          end else begin
            status_nxt = psd_pkg::ST_CLEAR;
          end
        end else begin
          status_nxt = psd_pkg::ST_NO_EXT;
        end
      end else begin
        // The PES length bytes and the payload carry nothing to check.
      end
    end else begin
      // Pack header bytes between the start code and the stuffing length, and the stuffing bytes.
    end

    // Result of this sector, taken from the updated flags.
    result.status   = status_nxt;
    result.verdict  = scr_nxt       ? psd_pkg::VD_SCRAMBLED :
                      valid_pes_nxt ? psd_pkg::VD_PLAIN : psd_pkg::VD_INCONCLUSIVE;
    result.is_final = scan_last;

    // Advance the position, or restart at a sector end.
    if (!sector_last) begin
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end else begin
      pos_nxt    = '0;
      off_nxt    = OFF_BASE;
      match_nxt  = 1'b1;
      ext_nxt    = 1'b0;
      status_nxt = psd_pkg::ST_NONE;
      if (scan_last) begin
        valid_pes_nxt = 1'b0;
        scr_nxt       = 1'b0;
      end
    end
  end

  // State registers update on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      off_r       <= OFF_BASE;
      match_r     <= 1'b1;
      ext_r       <= 1'b0;
      status_r    <= psd_pkg::ST_NONE;
      valid_pes_r <= 1'b0;
      scr_r       <= 1'b0;
    end else if (take) begin
      pos_r       <= pos_nxt;
      off_r       <= off_nxt;
      match_r     <= match_nxt;
      ext_r       <= ext_nxt;
      status_r    <= status_nxt;
      valid_pes_r <= valid_pes_nxt;
      scr_r       <= scr_nxt;
    end
  end

  // A scrambled PES is always also a valid one.
  `PSD_ASSERT(a_scr_implies_valid, scr_r |-> valid_pes_r, "scrambled flag without valid PES")
  // The scan flags are clear after the transfer that closes a scan.
  `PSD_ASSERT(a_scan_clear, (take && sector_last && scan_last) |=> (!scr_r && !valid_pes_r), "scan flags not cleared at scan end")
  // Position steps by one on a mid-sector transfer below saturation.
  `PSD_ASSERT(a_pos_step, (take && !sector_last && (pos_r != POS_MAX)) |=> (pos_r == $past(pos_r) + POS_W'(1)), "byte position did not advance")

endmodule
